// ===== src/ngga_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ngga_pkg
// Shared types and constants of the GGA sentence parser.
// ----------------------------------------------------------------------------
package ngga_pkg;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_TIME,
    KIND_LAT,
    KIND_LON,
    KIND_SATS,
    KIND_ALT
  } ngga_kind_t;

  localparam logic [3:0] FIELD_TIME = 4'd1;
  localparam logic [3:0] FIELD_LAT  = 4'd2;
  localparam logic [3:0] FIELD_NS   = 4'd3;
  localparam logic [3:0] FIELD_LON  = 4'd4;
  localparam logic [3:0] FIELD_EW   = 4'd5;
  localparam logic [3:0] FIELD_SATS = 4'd7;
  localparam logic [3:0] FIELD_ALT  = 4'd9;
  localparam logic [3:0] FIELD_MAX  = 4'd15;

  localparam logic [1:0] HEMI_FIRST  = 2'd1;
  localparam logic [1:0] HEMI_SECOND = 2'd2;

  localparam logic [19:0] TIME_MAX = 20'd999999;
  localparam logic [20:0] ALT_MAX  = 21'd999999;
  localparam logic [7:0]  SATS_MAX = 8'd255;

  // One transaction from the front to the back: a field commit, a hemisphere
  // update and a result request, any of which may be off.
  typedef struct packed {
    logic       commit_en;
    ngga_kind_t kind;
    logic [19:0] time_acc;
    logic [9:0]  frac_acc;
    logic [1:0]  frac_digits;
    logic [9:0]  deg_acc;
    logic [19:0] min_acc;
    logic [20:0] num_acc;
    logic        num_neg;
    logic        hemi_en;
    logic        hemi_lon;
    logic [1:0]  hemi_val;
    logic        emit;
    logic        ok;
  } ngga_txn_t;

endpackage

// ===== src/ngga_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ngga_queue
// Small register queue between the byte front and the commit back.
// ----------------------------------------------------------------------------
module ngga_queue #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_data;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== src/ngga_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ngga_front
// Byte front: counts fields, accumulates digits, issues commit transactions.
// ----------------------------------------------------------------------------
module ngga_front import ngga_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      accept,
  input  logic [7:0] ch,
  input  logic      first,
  input  logic      last,
  output logic      push,
  output ngga_txn_t txn
);

  logic [3:0]  field_index, field_index_next;
  logic [3:0]  char_position, char_position_next;
  logic        halted, halted_next;
  logic [19:0] time_acc, time_acc_next;
  logic [9:0]  frac_acc, frac_acc_next;
  logic [1:0]  frac_digits, frac_digits_next;
  logic        in_frac, in_frac_next;
  logic [9:0]  deg_acc, deg_acc_next;
  logic [19:0] min_acc, min_acc_next;
  logic [20:0] num_acc, num_acc_next;
  logic        num_neg, num_neg_next;

  function automatic logic [6:0] deg_weight(input logic [4:0] rel);
    case (rel)
      5'd0:    return 7'd100;
      5'd1:    return 7'd10;
      5'd2:    return 7'd1;
      default: return 7'd0;
    endcase
  endfunction

  function automatic logic [16:0] min_weight(input logic [4:0] rel);
    case (rel)
      5'd3:    return 17'd100000;
      5'd4:    return 17'd10000;
      5'd6:    return 17'd1000;
      5'd7:    return 17'd100;
      5'd8:    return 17'd10;
      5'd9:    return 17'd1;
      default: return 17'd0;
    endcase
  endfunction

  logic        is_digit, is_comma, is_star;
  logic [3:0]  d;
  logic [3:0]  e_field, e_cpos;
  logic        e_halted;
  logic [19:0] e_time;
  logic [9:0]  e_frac;
  logic [1:0]  e_fdig;
  logic        e_infrac;
  logic [9:0]  e_deg;
  logic [19:0] e_min;
  logic [20:0] e_num;
  logic        e_neg;
  logic [23:0] time_mul;
  logic [24:0] alt_mul;
  logic [21:0] alt_add;
  logic [11:0] sats_mul;
  logic [4:0]  rel;
  logic        sel_post;
  logic [3:0]  s_field, s_cpos;

  always_comb begin
    is_digit = (ch inside {[8'h30:8'h39]});
    is_comma = (ch == ",");
    is_star  = (ch == "*");
    d        = is_digit ? ch[3:0] : 4'd0;

    e_field  = first ? '0 : field_index;
    e_halted = first ? 1'b0 : halted;
    e_cpos   = first ? '0 : char_position;
    e_time   = first ? '0 : time_acc;
    e_frac   = first ? '0 : frac_acc;
    e_fdig   = first ? '0 : frac_digits;
    e_infrac = first ? 1'b0 : in_frac;
    e_deg    = first ? '0 : deg_acc;
    e_min    = first ? '0 : min_acc;
    e_num    = first ? '0 : num_acc;
    e_neg    = first ? 1'b0 : num_neg;

    field_index_next   = e_field;
    halted_next        = e_halted;
    char_position_next = e_cpos;
    time_acc_next      = e_time;
    frac_acc_next      = e_frac;
    frac_digits_next   = e_fdig;
    in_frac_next       = e_infrac;
    deg_acc_next       = e_deg;
    min_acc_next       = e_min;
    num_acc_next       = e_num;
    num_neg_next       = e_neg;

    time_mul = {e_time, 3'b000} + {3'b000, e_time, 1'b0} + {20'd0, d};
    sats_mul = {e_num[7:0], 3'b000} + {3'b000, e_num[7:0], 1'b0} + {8'd0, d};
    alt_mul  = {1'b0, e_num, 3'b000} + {3'b000, e_num, 1'b0}
             + {17'd0, d, 3'b000} + {20'd0, d, 1'b0};
    alt_add  = {1'b0, e_num} + {18'd0, d};
    rel      = (e_field == FIELD_LON) ? {1'b0, e_cpos} : {1'b0, e_cpos} + 5'd1;

    txn.hemi_en  = 1'b0;
    txn.hemi_lon = (e_field == FIELD_EW);
    txn.hemi_val = HEMI_FIRST;

    if (is_comma || is_star) begin
      field_index_next   = is_star ? FIELD_MAX :
                           (e_field == FIELD_MAX) ? e_field : e_field + 4'd1;
      char_position_next = '0;
      time_acc_next      = '0;
      frac_acc_next      = '0;
      frac_digits_next   = '0;
      in_frac_next       = 1'b0;
      deg_acc_next       = '0;
      min_acc_next       = '0;
      num_acc_next       = '0;
      num_neg_next       = 1'b0;
    end else if (!e_halted) begin
      char_position_next = (e_cpos == 4'd15) ? e_cpos : e_cpos + 4'd1;
      case (e_field)
        FIELD_TIME: begin
          if (ch == ".") begin
            in_frac_next = 1'b1;
          end else if (is_digit && !e_infrac) begin
            time_acc_next = (time_mul > {4'd0, TIME_MAX}) ? TIME_MAX : time_mul[19:0];
          end else if (is_digit && e_fdig < 2'd3) begin
            frac_acc_next    = 10'({e_frac, 3'b000} + {e_frac, 1'b0} + {6'd0, d});
            frac_digits_next = e_fdig + 2'd1;
          end
        end
        FIELD_LAT, FIELD_LON: begin
          deg_acc_next = e_deg + 10'(d * deg_weight(rel));
          min_acc_next = e_min + 20'(d * min_weight(rel));
        end
        FIELD_NS, FIELD_EW: begin
          if (e_cpos == '0) begin
            if (ch == ((e_field == FIELD_NS) ? "N" : "E")) begin
              txn.hemi_en  = 1'b1;
              txn.hemi_val = HEMI_FIRST;
            end else if (ch == ((e_field == FIELD_NS) ? "S" : "W")) begin
              txn.hemi_en  = 1'b1;
              txn.hemi_val = HEMI_SECOND;
            end else begin
              halted_next = 1'b1;
            end
          end
        end
        FIELD_SATS: begin
          if (is_digit) begin
            num_acc_next = (sats_mul > {4'd0, SATS_MAX}) ? 21'(SATS_MAX) :
                           21'(sats_mul);
          end
        end
        FIELD_ALT: begin
          if (ch == "-" && e_cpos == '0) begin
            num_neg_next = 1'b1;
          end else if (ch == ".") begin
            in_frac_next = 1'b1;
          end else if (is_digit && !e_infrac) begin
            num_acc_next = (alt_mul > {4'd0, ALT_MAX}) ? ALT_MAX : alt_mul[20:0];
          end else if (is_digit && e_fdig == '0) begin
            num_acc_next     = (alt_add > {1'b0, ALT_MAX}) ? ALT_MAX : alt_add[20:0];
            frac_digits_next = 2'd1;
          end
        end
        default: begin
        end
      endcase
    end

    sel_post = !(is_comma || is_star);
    s_field  = sel_post ? field_index_next : e_field;
    s_cpos   = sel_post ? char_position_next : e_cpos;

    case (s_field)
      FIELD_TIME: txn.kind = KIND_TIME;
      FIELD_LAT:  txn.kind = KIND_LAT;
      FIELD_LON:  txn.kind = KIND_LON;
      FIELD_SATS: txn.kind = KIND_SATS;
      FIELD_ALT:  txn.kind = KIND_ALT;
      default:    txn.kind = KIND_NONE;
    endcase

    txn.commit_en   = (is_comma || is_star || last) && !halted_next &&
                      (s_cpos != '0) && (txn.kind != KIND_NONE);
    txn.time_acc    = sel_post ? time_acc_next : e_time;
    txn.frac_acc    = sel_post ? frac_acc_next : e_frac;
    txn.frac_digits = sel_post ? frac_digits_next : e_fdig;
    txn.deg_acc     = sel_post ? deg_acc_next : e_deg;
    txn.min_acc     = sel_post ? min_acc_next : e_min;
    txn.num_acc     = sel_post ? num_acc_next : e_num;
    txn.num_neg     = sel_post ? num_neg_next : e_neg;
    txn.emit        = last;
    txn.ok          = !halted_next;

    push = accept && (txn.commit_en || txn.hemi_en || last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_index   <= '0;
      char_position <= '0;
      halted        <= 1'b0;
      time_acc      <= '0;
      frac_acc      <= '0;
      frac_digits   <= '0;
      in_frac       <= 1'b0;
      deg_acc       <= '0;
      min_acc       <= '0;
      num_acc       <= '0;
      num_neg       <= 1'b0;
    end else if (accept) begin
      field_index   <= field_index_next;
      char_position <= char_position_next;
      halted        <= halted_next;
      time_acc      <= time_acc_next;
      frac_acc      <= frac_acc_next;
      frac_digits   <= frac_digits_next;
      in_frac       <= in_frac_next;
      deg_acc       <= deg_acc_next;
      min_acc       <= min_acc_next;
      num_acc       <= num_acc_next;
      num_neg       <= num_neg_next;
    end
  end

endmodule

// ===== src/ngga_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ngga_back
// Commit back: converts field values in four stages, updates the kept
// values in order and registers the result.
// ----------------------------------------------------------------------------
module ngga_back import ngga_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_empty,
  input  ngga_txn_t   q_data,
  output logic        q_pop,
  output logic        result_valid,
  input  logic        result_stall,
  output logic        ok,
  output logic [6:0]  hour,
  output logic [6:0]  minute,
  output logic [6:0]  second,
  output logic [9:0]  millisecond,
  output logic [29:0] lat_fixed,
  output logic [1:0]  lat_hemi,
  output logic [33:0] lon_fixed,
  output logic [1:0]  lon_hemi,
  output logic [7:0]  satellites,
  output logic signed [20:0] altitude_tenths
);

  localparam logic [23:0] RECIP_10000 = 24'd13743896;
  localparam logic [26:0] RECIP_3     = 27'd44739243;
  localparam logic [13:0] RECIP_100   = 14'd10486;

  typedef struct packed {
    ngga_txn_t   txn;
    logic [6:0]  hour;
    logic [9:0]  ms;
    logic [20:0] alt;
    logic [25:0] p50;
    logic [33:0] degp;
    logic [13:0] rem;
    logic [23:0] q3;
    logic [6:0]  minute;
    logic [33:0] coord;
  } stage_t;

  function automatic logic [9:0] ms_scale(input logic [1:0] n);
    case (n)
      2'd0:    return 10'd1000;
      2'd1:    return 10'd100;
      2'd2:    return 10'd10;
      default: return 10'd1;
    endcase
  endfunction

  logic   en;
  logic   s1_valid, s2_valid, s3_valid, s4_valid;
  stage_t s1, s2, s3, s4;
  stage_t s1_next, s2_next, s3_next;
  logic [43:0] hour_prod;
  logic [52:0] q3_prod;
  logic [27:0] min_prod;
  logic [13:0] sec_full;

  logic [6:0]  k_hour, k_hour_next, k_minute, k_minute_next, k_second, k_second_next;
  logic [9:0]  k_ms, k_ms_next;
  logic [29:0] k_lat, k_lat_next;
  logic [1:0]  k_lat_hemi, k_lat_hemi_next, k_lon_hemi, k_lon_hemi_next;
  logic [33:0] k_lon, k_lon_next;
  logic [7:0]  k_sats, k_sats_next;
  logic [20:0] k_alt, k_alt_next;

  assign en    = !(result_valid && result_stall);
  assign q_pop = en && !q_empty;

  always_comb begin
    s1_next      = s1;
    s1_next.txn  = q_data;
    hour_prod    = q_data.time_acc * RECIP_10000;
    s1_next.hour = hour_prod[43:37];
    s1_next.ms   = 10'(q_data.frac_acc * ms_scale(q_data.frac_digits));
    s1_next.alt  = q_data.num_neg ? 21'(-q_data.num_acc) : q_data.num_acc;
    s1_next.p50  = 26'(q_data.min_acc * 6'd50);
    s1_next.degp = 34'(q_data.deg_acc * 24'd10000000);

    s2_next      = s1;
    s2_next.rem  = 14'(s1.txn.time_acc - 20'(s1.hour * 14'd10000));
    q3_prod      = s1.p50 * RECIP_3;
    s2_next.q3   = q3_prod[50:27];

    s3_next        = s2;
    min_prod       = s2.rem * RECIP_100;
    s3_next.minute = min_prod[26:20];
    s3_next.coord  = s2.degp + {10'd0, s2.q3};

    sec_full = s4.rem - 14'(s4.minute * 7'd100);

    k_hour_next     = k_hour;
    k_minute_next   = k_minute;
    k_second_next   = k_second;
    k_ms_next       = k_ms;
    k_lat_next      = k_lat;
    k_lon_next      = k_lon;
    k_sats_next     = k_sats;
    k_alt_next      = k_alt;
    k_lat_hemi_next = k_lat_hemi;
    k_lon_hemi_next = k_lon_hemi;
    if (s4.txn.commit_en) begin
      case (s4.txn.kind)
        KIND_TIME: begin
          k_hour_next   = s4.hour;
          k_minute_next = s4.minute;
          k_second_next = sec_full[6:0];
          k_ms_next     = s4.ms;
        end
        KIND_LAT:  k_lat_next  = s4.coord[29:0];
        KIND_LON:  k_lon_next  = s4.coord;
        KIND_SATS: k_sats_next = s4.txn.num_acc[7:0];
        KIND_ALT:  k_alt_next  = s4.alt;
        default: begin
        end
      endcase
    end
    if (s4.txn.hemi_en) begin
      if (s4.txn.hemi_lon) begin
        k_lon_hemi_next = s4.txn.hemi_val;
      end else begin
        k_lat_hemi_next = s4.txn.hemi_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= s1_next;
      s2 <= s2_next;
      s3 <= s3_next;
      s4 <= s3;
      if (s4_valid && s4.txn.emit) begin
        ok              <= s4.txn.ok;
        hour            <= k_hour_next;
        minute          <= k_minute_next;
        second          <= k_second_next;
        millisecond     <= k_ms_next;
        lat_fixed       <= k_lat_next;
        lat_hemi        <= k_lat_hemi_next;
        lon_fixed       <= k_lon_next;
        lon_hemi        <= k_lon_hemi_next;
        satellites      <= k_sats_next;
        altitude_tenths <= k_alt_next;
      end
    end
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      s4_valid     <= 1'b0;
      result_valid <= 1'b0;
      k_hour       <= '0;
      k_minute     <= '0;
      k_second     <= '0;
      k_ms         <= '0;
      k_lat        <= '0;
      k_lon        <= '0;
      k_sats       <= '0;
      k_alt        <= '0;
      k_lat_hemi   <= '0;
      k_lon_hemi   <= '0;
    end else if (en) begin
      s1_valid     <= q_pop;
      s2_valid     <= s1_valid;
      s3_valid     <= s2_valid;
      s4_valid     <= s3_valid;
      result_valid <= s4_valid && s4.txn.emit;
      if (s4_valid) begin
        k_hour     <= k_hour_next;
        k_minute   <= k_minute_next;
        k_second   <= k_second_next;
        k_ms       <= k_ms_next;
        k_lat      <= k_lat_next;
        k_lon      <= k_lon_next;
        k_sats     <= k_sats_next;
        k_alt      <= k_alt_next;
        k_lat_hemi <= k_lat_hemi_next;
        k_lon_hemi <= k_lon_hemi_next;
      end
    end
  end

endmodule

// ===== src/nmea_gga_sentence_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_gga_sentence_parser
// Parses GGA sentence bytes into time, position, satellites and altitude.
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+----------------------------------
//   byte in  | byte_valid / byte_stall     | ch, first, last
//   result   | result_valid / result_stall | ok, hour .. altitude_tenths
//
// One byte per cycle while byte_stall is low. After its last byte is taken, a
// result passes the queue, four conversion stages and the output register.
// Synchronous reset clears field counting, accumulators and kept values.
// byte_stall rises only when the internal queue is full, which happens
// only after result_stall has held a result in the output register.
// ----------------------------------------------------------------------------
module nmea_gga_sentence_parser import ngga_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  ch,
  input  logic        first,
  input  logic        last,
  output logic        result_valid,
  input  logic        result_stall,
  output logic        ok,
  output logic [6:0]  hour,
  output logic [6:0]  minute,
  output logic [6:0]  second,
  output logic [9:0]  millisecond,
  output logic [29:0] lat_fixed,
  output logic [1:0]  lat_hemi,
  output logic [33:0] lon_fixed,
  output logic [1:0]  lon_hemi,
  output logic [7:0]  satellites,
  output logic signed [20:0] altitude_tenths
);

  logic      accept;
  logic      push;
  logic      q_full;
  logic      q_empty;
  logic      q_pop;
  ngga_txn_t push_txn;
  ngga_txn_t pop_txn;

  assign byte_stall = q_full;
  assign accept     = byte_valid && !q_full;

  ngga_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .ch     (ch),
    .first  (first),
    .last   (last),
    .push   (push),
    .txn    (push_txn)
  );

  ngga_queue #(
    .WIDTH ($bits(ngga_txn_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_txn),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_txn),
    .empty     (q_empty)
  );

  ngga_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_empty         (q_empty),
    .q_data          (pop_txn),
    .q_pop           (q_pop),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .ok              (ok),
    .hour            (hour),
    .minute          (minute),
    .second          (second),
    .millisecond     (millisecond),
    .lat_fixed       (lat_fixed),
    .lat_hemi        (lat_hemi),
    .lon_fixed       (lon_fixed),
    .lon_hemi        (lon_hemi),
    .satellites      (satellites),
    .altitude_tenths (altitude_tenths)
  );

endmodule

// ===== bench/ngga_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ngga_checker
// Watches the byte and result channels of the GGA parser. It runs its own
// parse of every accepted byte, queues the fix it expects on each last byte,
// and compares every accepted result field by field against the oldest fix.
// ----------------------------------------------------------------------------
module ngga_checker import ngga_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  input  logic        byte_stall,
  input  logic [7:0]  ch,
  input  logic        first,
  input  logic        last,
  input  logic        result_valid,
  input  logic        result_stall,
  input  logic        ok,
  input  logic [6:0]  hour,
  input  logic [6:0]  minute,
  input  logic [6:0]  second,
  input  logic [9:0]  millisecond,
  input  logic [29:0] lat_fixed,
  input  logic [1:0]  lat_hemi,
  input  logic [33:0] lon_fixed,
  input  logic [1:0]  lon_hemi,
  input  logic [7:0]  satellites,
  input  logic signed [20:0] altitude_tenths,
  output int          fail_count,
  output int          pending
);

  typedef struct {
    logic        ok;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic [9:0]  ms;
    logic [29:0] lat;
    logic [1:0]  lat_h;
    logic [33:0] lon;
    logic [1:0]  lon_h;
    logic [7:0]  sats;
    logic [20:0] alt;
  } gga_fix_t;

  gga_fix_t fix_q[$];

  logic [3:0] field_no, char_no;
  logic       halted;
  longint unsigned time_int, frac_val, frac_cnt, deg_val, min_val, num_val;
  logic       in_frac, num_neg;

  logic [6:0]  k_hour, k_minute, k_second;
  logic [9:0]  k_ms;
  logic [29:0] k_lat;
  logic [33:0] k_lon;
  logic [1:0]  k_lat_h, k_lon_h;
  logic [7:0]  k_sats;
  logic [20:0] k_alt;

  task automatic clear_fields();
    char_no = 0; time_int = 0; frac_val = 0; frac_cnt = 0; in_frac = 0;
    deg_val = 0; min_val = 0; num_val = 0; num_neg = 0;
  endtask

  task automatic commit_field();
    longint unsigned scale;
    if (halted || char_no == 0) return;
    case (field_no)
      FIELD_TIME: begin
        k_hour = 7'(time_int / 10000);
        k_minute = 7'((time_int % 10000) / 100);
        k_second = 7'(time_int % 100);
        case (frac_cnt)
          0: scale = 1000;
          1: scale = 100;
          2: scale = 10;
          default: scale = 1;
        endcase
        k_ms = 10'(frac_val * scale);
      end
      FIELD_LAT: k_lat = 30'(deg_val * 64'd10000000 + (64'd50 * min_val) / 3);
      FIELD_LON: k_lon = 34'(deg_val * 64'd10000000 + (64'd50 * min_val) / 3);
      FIELD_SATS: k_sats = 8'(num_val);
      FIELD_ALT: k_alt = num_neg ? 21'(64'd0 - num_val) : 21'(num_val);
      default: ;
    endcase
  endtask

  task automatic coord_digit(int pos, logic [7:0] c, int dw);
    longint unsigned d, w;
    d = (c >= "0" && c <= "9") ? c - "0" : 0;
    if (pos < dw) begin
      w = 1;
      for (int k = pos + 1; k < dw; k++) w *= 10;
      deg_val += d * w;
    end else if (pos == dw) begin
      min_val += d * 100000;
    end else if (pos == dw + 1) begin
      min_val += d * 10000;
    end else if (pos >= dw + 3 && pos <= dw + 6) begin
      case (pos - dw - 3)
        0: min_val += d * 1000;
        1: min_val += d * 100;
        2: min_val += d * 10;
        default: min_val += d;
      endcase
    end
  endtask

  task automatic body_byte(logic [7:0] c);
    logic dig;
    longint unsigned d;
    dig = c >= "0" && c <= "9";
    d = dig ? c - "0" : 0;
    case (field_no)
      FIELD_TIME: begin
        if (c == ".") in_frac = 1;
        else if (dig && !in_frac) begin
          time_int = time_int * 10 + d;
          if (time_int > TIME_MAX) time_int = TIME_MAX;
        end else if (dig && frac_cnt < 3) begin
          frac_val = frac_val * 10 + d;
          frac_cnt++;
        end
      end
      FIELD_LAT: coord_digit(char_no, c, 2);
      FIELD_LON: coord_digit(char_no, c, 3);
      FIELD_NS: if (char_no == 0) begin
        if (c == "N") k_lat_h = HEMI_FIRST;
        else if (c == "S") k_lat_h = HEMI_SECOND;
        else halted = 1;
      end
      FIELD_EW: if (char_no == 0) begin
        if (c == "E") k_lon_h = HEMI_FIRST;
        else if (c == "W") k_lon_h = HEMI_SECOND;
        else halted = 1;
      end
      FIELD_SATS: if (dig) begin
        num_val = num_val * 10 + d;
        if (num_val > SATS_MAX) num_val = SATS_MAX;
      end
      FIELD_ALT: begin
        if (c == "-" && char_no == 0) num_neg = 1;
        else if (c == ".") in_frac = 1;
        else if (dig && !in_frac) begin
          num_val = num_val * 10 + d * 10;
          if (num_val > ALT_MAX) num_val = ALT_MAX;
        end else if (dig && frac_cnt == 0) begin
          num_val += d;
          if (num_val > ALT_MAX) num_val = ALT_MAX;
          frac_cnt = 1;
        end
      end
      default: ;
    endcase
  endtask

  task automatic parse_byte(logic [7:0] c, logic f, logic l);
    gga_fix_t fx;
    if (f) begin
      field_no = 0; halted = 0; clear_fields();
    end
    if (c == ",") begin
      commit_field();
      if (field_no < FIELD_MAX) field_no++;
      clear_fields();
    end else if (c == "*") begin
      commit_field();
      field_no = FIELD_MAX;
      clear_fields();
    end else if (!halted) begin
      body_byte(c);
      if (char_no < 15) char_no++;
    end
    if (l) begin
      commit_field();
      fx.ok = !halted; fx.hour = k_hour; fx.minute = k_minute; fx.second = k_second;
      fx.ms = k_ms; fx.lat = k_lat; fx.lat_h = k_lat_h; fx.lon = k_lon;
      fx.lon_h = k_lon_h; fx.sats = k_sats; fx.alt = k_alt;
      fix_q.push_back(fx);
    end
  endtask

  task automatic check_field(string name, longint unsigned e, longint unsigned a);
    if (e != a) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, e, a);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    gga_fix_t fx;
    if (rst) begin
      field_no = 0; halted = 0; clear_fields();
      k_hour = 0; k_minute = 0; k_second = 0; k_ms = 0; k_lat = 0; k_lon = 0;
      k_lat_h = 0; k_lon_h = 0; k_sats = 0; k_alt = 0;
      fix_q.delete();
      fail_count = 0;
    end else begin
      if (byte_valid && !byte_stall) parse_byte(ch, first, last);
      if (result_valid && !result_stall) begin
        if (fix_q.size() == 0) begin
          $display("%0t: result with no fix expected, expected none, actual ok=%0d",
                   $realtime, ok);
          fail_count++;
        end else begin
          fx = fix_q.pop_front();
          check_field("ok", fx.ok, ok);
          check_field("hour", fx.hour, hour);
          check_field("minute", fx.minute, minute);
          check_field("second", fx.second, second);
          check_field("millisecond", fx.ms, millisecond);
          check_field("lat_fixed", fx.lat, lat_fixed);
          check_field("lat_hemi", fx.lat_h, lat_hemi);
          check_field("lon_fixed", fx.lon, lon_fixed);
          check_field("lon_hemi", fx.lon_h, lon_hemi);
          check_field("satellites", fx.sats, satellites);
          check_field("altitude_tenths", fx.alt, altitude_tenths[20:0]);
        end
      end
    end
    pending = fix_q.size();
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Feeds the GGA parser directed and random sentences, well formed and broken,
// in bursts with random gaps while the result side stalls on its own pattern.
// The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import ngga_pkg::*;

  logic        clk;
  logic        rst;
  logic        byte_valid;
  logic        byte_stall;
  logic [7:0]  ch;
  logic        first;
  logic        last;
  logic        result_valid;
  logic        result_stall;
  logic        ok;
  logic [6:0]  hour, minute, second;
  logic [9:0]  millisecond;
  logic [29:0] lat_fixed;
  logic [1:0]  lat_hemi;
  logic [33:0] lon_fixed;
  logic [1:0]  lon_hemi;
  logic [7:0]  satellites;
  logic signed [20:0] altitude_tenths;
  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  int          burst_left;
  int          sent_bytes;
  int          stall_phase;

  localparam int CYCLE_LIMIT = 400000;

  nmea_gga_sentence_parser u_dut (.*);

  ngga_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 0;
      stall_phase <= 0;
    end else begin
      stall_phase <= stall_phase + 1;
      case (stall_phase[9:8])
        0: result_stall <= 0;
        1: result_stall <= ($urandom % 4) == 0;
        2: result_stall <= ($urandom % 4) != 0;
        default: result_stall <= stall_phase[4];
      endcase
    end
  end

  task automatic send_byte(logic [7:0] b, logic f, logic l);
    if (burst_left == 0) begin
      byte_valid <= 0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom % 5 == 0) ? $urandom_range(60, 200) : $urandom_range(1, 30);
    end
    byte_valid <= 1;
    ch <= b;
    first <= f;
    last <= l;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    burst_left--;
    sent_bytes++;
  endtask

  task automatic send_text(string s, bit with_first);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], with_first && i == 0, i == s.len() - 1);
  endtask

  function automatic string digits(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(8'("0" + $urandom_range(0, 9)))};
    return s;
  endfunction

  function automatic string pick_hemi(string a, string b);
    int r;
    string bad;
    r = $urandom_range(0, 99);
    bad = "XnsQ1 e";
    if (r < 10) return "";
    if (r < 16) return string'(bad[$urandom_range(0, 6)]);
    if (r < 58) return {a, (r % 3 == 0) ? "x" : ""};
    return b;
  endfunction

  function automatic string opt(string s);
    return ($urandom % 10 == 0) ? "" : s;
  endfunction

  function automatic string random_sentence();
    string t, la, lo, sa, al, s;
    t = {digits($urandom_range(0, 8)), ($urandom % 4 != 0) ? "." : "",
         digits($urandom_range(0, 5))};
    la = {digits($urandom_range(0, 5)), ($urandom % 5 != 0) ? "." : "",
          digits($urandom_range(0, 7))};
    lo = {digits($urandom_range(0, 6)), ($urandom % 5 != 0) ? "." : "",
          digits($urandom_range(0, 7))};
    sa = digits($urandom_range(0, 4));
    al = {($urandom % 3 == 0) ? "-" : "", digits($urandom_range(0, 7)),
          ($urandom % 3 != 0) ? {".", digits($urandom_range(0, 3))} : ""};
    s = {"$GPGGA,", opt(t), ",", opt(la), ",", pick_hemi("N", "S"), ",", opt(lo), ",",
         pick_hemi("E", "W"), ",1,", opt(sa), ",0.9,", opt(al), ",M,46.9,M,,"};
    if ($urandom % 4 != 0) s = {s, "*", digits(2)};
    if ($urandom % 5 == 0) s = s.substr(0, $urandom_range(0, s.len() - 1));
    for (int n = $urandom_range(0, 2); n > 0; n--)
      s[$urandom_range(0, s.len() - 1)] = 8'($urandom_range(0, 255));
    return s;
  endfunction

  initial begin
    rst = 1;
    byte_valid = 0;
    ch = 0;
    first = 0;
    last = 0;
    burst_left = 0;
    sent_bytes = 0;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send_text("$GPGGA,999999.999,9959.9999,S,17959.9999,W,1,99999,0.9,-9999999.9,M*", 1);
    send_text("$GPGGA,000000.000,0000.0000,N,00000.0000,E,0,0,0,0.0,M", 1);
    send_text("$GPGGA,,,,,,,,,,,,,,,,,,,,", 1);
    send_text("$GPGGA,1.2.3,ab1.x,X,12,E,1,a9,0,12.34,M", 1);
    send_text("$GPGGA,123456.78,4807.038,Q,01131.000,E,1,08*2A,99", 1);
    send_text("$GPGGA,235959,4,N,9,W,1,7,0,-.5", 1);
    send_text("12,34", 0);

    while (sent_bytes < 1250) begin
      if ($urandom % 8 == 0) begin
        for (int n = $urandom_range(1, 20); n > 0; n--)
          send_byte(8'($urandom_range(0, 255)), $urandom % 6 == 0, $urandom % 6 == 0);
      end else begin
        send_text(random_sentence(), $urandom % 10 != 0);
      end
    end

    byte_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
